@@ sv/rtds_pkg.sv @@
// Package for the RGBA [1,2,1] half-size decimator.
// Holds payload structs, controller state type and command/status structs.
package rtds_pkg;

	localparam int unsigned CfgWidthW = 13;
	localparam int unsigned ChanW = 16;
	localparam int unsigned AlphaW = 13;
	localparam int unsigned SumW = 20;
	localparam int unsigned QuotW = 17;

	localparam logic CfgWidthIdx = 1'b0;
	localparam logic CfgHeightIdx = 1'b1;

	typedef struct packed {
		logic [15:0] in_red;
		logic [15:0] in_green;
		logic [15:0] in_blue;
		logic [12:0] in_alpha;
	} pix_in_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [12:0] out_alpha;
		logic frame_end;
	} pix_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} rtds_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch input item, issue memory read
		logic col_sum;    // form vertical sums, update stores
		logic emit_calc;  // form 2D sums and start divider
		logic div_step;   // one quotient bit
		logic load_out;   // move result to output register
	} rtds_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_frame;   // captured pixel is inside the active area
		logic odd_row;
		logic odd_col;
		logic div_done;
		logic out_busy;   // output register still holds a result
	} rtds_stat_t;

endpackage

@@ sv/rtds_ctrl.sv @@
// Controller state machine of the decimator.
// Depends on rtds_pkg for state and command/status structs.
module rtds_ctrl import rtds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  rtds_stat_t stat,
	output rtds_cmd_t  cmd
);

	rtds_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_READ;
			end
			ST_READ: state_d = ST_SUM;
			ST_SUM: begin
				if (stat.in_frame && stat.odd_row && stat.odd_col) state_d = ST_DIV;
				else state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SUM: begin
				cmd.col_sum = 1'b1;
				cmd.emit_calc = stat.in_frame && stat.odd_row && stat.odd_col;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_OUT: cmd.load_out = !stat.out_busy;
			default: ;
		endcase
	end

endmodule

@@ sv/rtds_dp.sv @@
// Datapath of the decimator: counters, row stores, column sums, serial divider,
// output register. Depends on rtds_pkg.
module rtds_dp import rtds_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pix_in_t     pix_in,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  rtds_cmd_t   cmd,
	output rtds_stat_t  stat,
	output logic        out_valid,
	input  logic        out_ready,
	output pix_out_t    pix_out
);

	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned DivSteps = 32;

	logic [CW-1:0] width_q;
	logic [RW-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [63:0] upper_mem [MAX_WIDTH];
	logic [63:0] middle_mem [MAX_WIDTH];
	logic [63:0] up_rd_q, mid_rd_q, pix_q;
	logic [CW-1:0] ccol_q;
	logic [RW-1:0] crow_q;
	logic [17:0] left_q [4];
	logic [17:0] midc_q [4];
	logic [17:0] v [4];
	logic [19:0] s [4];
	logic last_q;
	logic [19:0] sa_q;
	logic [19:0] sc_q [3];
	logic [33:0] rem_q [3];
	logic [31:0] num_q [3];
	logic [16:0] quo_q [3];
	logic [5:0] step_q;
	logic [CW-1:0] width_in;
	logic [RW-1:0] height_in;

	// clamp register value to [2, max]
	always_comb begin
		if (cfg_data < 13'd2) width_in = CW'(2);
		else if ({19'd0, cfg_data} > 32'(MAX_WIDTH)) width_in = CW'(MAX_WIDTH);
		else width_in = CW'(cfg_data);
		if (cfg_data < 13'd2) height_in = RW'(2);
		else if ({19'd0, cfg_data} > 32'(MAX_HEIGHT)) height_in = RW'(MAX_HEIGHT);
		else height_in = RW'(cfg_data);
	end

	wire in_frame = ccol_q < width_q && crow_q < height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CW'(1024 > MAX_WIDTH ? MAX_WIDTH : 1024);
			height_q <= RW'(512 > MAX_HEIGHT ? MAX_HEIGHT : 512);
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < 4; k++) begin
				left_q[k] <= '0;
				midc_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CfgWidthIdx) width_q <= width_in;
			else height_q <= height_in;
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < 4; k++) begin
				left_q[k] <= '0;
				midc_q[k] <= '0;
			end
		end else begin
			if (cmd.capture) begin
				if (col_q + 1'b1 >= width_q) begin
					col_q <= '0;
					row_q <= (row_q + 1'b1 >= height_q) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (cmd.col_sum && in_frame && crow_q[0]) begin
				for (int k = 0; k < 4; k++) begin
					if (!ccol_q[0]) midc_q[k] <= v[k];
					else left_q[k] <= v[k];
				end
			end
		end
	end

	// capture and memory read; lanes packed red lowest, alpha highest
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= {3'b000, pix_in.in_alpha, pix_in.in_blue, pix_in.in_green,
				pix_in.in_red};
			ccol_q <= col_q;
			crow_q <= row_q;
			up_rd_q <= upper_mem[col_q[AW-1:0]];
			mid_rd_q <= middle_mem[col_q[AW-1:0]];
		end
		if (cmd.col_sum && in_frame) begin
			if (!crow_q[0]) middle_mem[ccol_q[AW-1:0]] <= pix_q;
			else upper_mem[ccol_q[AW-1:0]] <= pix_q;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			v[k] = 18'((crow_q == RW'(1)) ? pix_q[16*k +: 16] : up_rd_q[16*k +: 16])
				+ {1'b0, mid_rd_q[16*k +: 16], 1'b0} + 18'(pix_q[16*k +: 16]);
			s[k] = 20'((ccol_q == CW'(1)) ? v[k] : left_q[k]) + {1'b0, midc_q[k], 1'b0}
				+ 20'(v[k]);
		end
	end

	// restoring divider: q = (s*8192 + sa) / (2*sa), one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.emit_calc) begin
			step_q <= '0;
		end else if (cmd.div_step && step_q != 6'(DivSteps)) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_calc) begin
			sa_q <= s[3];
			last_q <= (crow_q >> 1) == (height_q >> 1) - 1'b1
				&& (ccol_q >> 1) == (width_q >> 1) - 1'b1;
			for (int k = 0; k < 3; k++) begin
				sc_q[k] <= s[k];
				num_q[k] <= {s[k], 12'd0} + 32'(s[3] >> 1);
				rem_q[k] <= '0;
				quo_q[k] <= '0;
			end
		end else if (cmd.div_step && step_q != 6'(DivSteps)) begin
			for (int k = 0; k < 3; k++) begin
				logic [33:0] t;
				t = {rem_q[k][32:0], num_q[k][31]};
				num_q[k] <= {num_q[k][30:0], 1'b0};
				if (t >= {14'd0, sa_q}) begin
					rem_q[k] <= t - {14'd0, sa_q};
					if (step_q >= 6'd16) quo_q[k] <= {quo_q[k][16], quo_q[k][14:0], 1'b1};
					else quo_q[k][16] <= 1'b1;
				end else begin
					rem_q[k] <= t;
					if (step_q >= 6'd16) quo_q[k] <= {quo_q[k][16], quo_q[k][14:0], 1'b0};
				end
			end
		end
	end

	// Note: numerator is s*4096 + floor(sa/2) over sa, identical to the
	// (s*8192+sa)/(2sa) rounding. Quotient bits 31..16 fold into sticky bit 16,
	// which marks saturation.

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pix_out.frame_end <= last_q;
			if (sa_q != '0) begin
				pix_out.out_red <= quo_q[0][16] ? 16'hffff : quo_q[0][15:0];
				pix_out.out_green <= quo_q[1][16] ? 16'hffff : quo_q[1][15:0];
				pix_out.out_blue <= quo_q[2][16] ? 16'hffff : quo_q[2][15:0];
				pix_out.out_alpha <= 13'd4096;
			end else begin
				pix_out.out_red <= 16'((sc_q[0] + 20'd8) >> 4);
				pix_out.out_green <= 16'((sc_q[1] + 20'd8) >> 4);
				pix_out.out_blue <= 16'((sc_q[2] + 20'd8) >> 4);
				pix_out.out_alpha <= '0;
			end
		end
	end

	assign stat.in_frame = in_frame;
	assign stat.odd_row = crow_q[0];
	assign stat.odd_col = ccol_q[0];
	assign stat.div_done = step_q == 6'(DivSteps) || sa_q == '0;
	assign stat.out_busy = out_valid && !out_ready;

endmodule

@@ sv/rgba_triangle_downscale_by_two.sv @@
// Top level of the RGBA [1,2,1] half-size decimator.
// Depends on rtds_pkg, rtds_ctrl and rtds_dp.
//
// Takes RGBA pixels in raster order and emits the half-size frame, one result
// per odd/odd source pixel. A transaction with no result passes the idle, read
// and sum states; one that completes an output pixel also passes the divide and
// output states; with nonzero alpha it waits for the bit-serial divider
// (one quotient bit per cycle, 32 steps) that normalises the colours by the
// filtered alpha; zero alpha skips the division. The output state waits while
// the output side stalls. Row stores are single-port memories read at capture,
// data used in the sum state. A register write restarts the frame. No clearing
// pass: the row stores are always written before they are read within a frame.
module rgba_triangle_downscale_by_two import rtds_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pix_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pix_out_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	rtds_cmd_t  cmd;
	rtds_stat_t stat;

	rtds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	rtds_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .pix_in(in_data), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
		.out_valid(out_valid), .out_ready(out_ready), .pix_out(out_data)
	);

	// a result is never loaded over one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid && !out_ready))
		else $error("output overwritten");

	// output alpha is one or zero only
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.out_alpha == 13'd4096 || out_data.out_alpha == 13'd0))
		else $error("bad output alpha");

	// no new transaction while a capture is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("back-to-back capture");

endmodule

@@ sim/tb_top.sv @@
// Testbench for rgba_triangle_downscale_by_two: directed table then random frames.
// Depends on rtds_pkg and the decimator RTL; compares each output transaction
// against an in-bench predictor of the [1,2,1] half-size filter.
module tb_top;
	import rtds_pkg::*;

	localparam int MaxW = 4096;
	localparam int MaxH = 4096;
	localparam int WatchLimit = 20000;
	localparam int MaxErrReport = 10;
	localparam int RandItems = 1750;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pix_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_out_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = CfgWidthIdx;
	logic [12:0] cfg_data = '0;

	always #10 clk = ~clk;

	rgba_triangle_downscale_by_two DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state: sizes, row stores, column sums and raster position
	int unsigned frame_w, frame_h;
	logic [63:0] upper_row [MaxW];
	logic [63:0] mid_row [MaxW];
	int unsigned left_sum [4];
	int unsigned mid_sum [4];
	int unsigned col_pos, row_pos;

	pix_out_t expected_pixels [$];
	int mismatches = 0;
	int pixels_in = 0;
	int pixels_out = 0;
	int frames_done = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;

	function automatic int unsigned clamp_size(logic [12:0] v, int unsigned hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = 0;
		for (int k = 0; k < 4; k++) begin
			left_sum[k] = 0;
			mid_sum[k] = 0;
		end
	endfunction

	function automatic void apply_size(logic idx, logic [12:0] v);
		if (idx == CfgWidthIdx) frame_w = clamp_size(v, MaxW);
		else frame_h = clamp_size(v, MaxH);
		restart_frame();
	endfunction

	// Advance the filter model by one source pixel; queue the output if one falls due.
	function automatic void decimate_pixel(pix_in_t p);
		int unsigned ch [4];
		int unsigned v [4];
		int unsigned s [4];
		logic [63:0] packed_px, up, mid;
		longint unsigned q, den;
		pix_out_t o;
		ch[0] = p.in_red;
		ch[1] = p.in_green;
		ch[2] = p.in_blue;
		ch[3] = p.in_alpha;
		packed_px = {3'b000, p.in_alpha, p.in_blue, p.in_green, p.in_red};
		if (col_pos < frame_w && row_pos < frame_h) begin
			if (row_pos[0] == 1'b0) begin
				mid_row[col_pos] = packed_px;
			end else begin
				up = (row_pos == 1) ? packed_px : upper_row[col_pos];
				mid = mid_row[col_pos];
				for (int k = 0; k < 4; k++)
					v[k] = up[16*k +: 16] + 2 * mid[16*k +: 16] + ch[k];
				upper_row[col_pos] = packed_px;
				if (col_pos[0] == 1'b0) begin
					for (int k = 0; k < 4; k++) mid_sum[k] = v[k];
				end else begin
					for (int k = 0; k < 4; k++) begin
						s[k] = ((col_pos == 1) ? v[k] : left_sum[k]) + 2 * mid_sum[k] + v[k];
						left_sum[k] = v[k];
					end
					if (s[3] > 0) begin
						den = 2 * longint'(s[3]);
						q = (longint'(s[0]) * 8192 + s[3]) / den;
						o.out_red = (q > 65535) ? 16'hFFFF : q[15:0];
						q = (longint'(s[1]) * 8192 + s[3]) / den;
						o.out_green = (q > 65535) ? 16'hFFFF : q[15:0];
						q = (longint'(s[2]) * 8192 + s[3]) / den;
						o.out_blue = (q > 65535) ? 16'hFFFF : q[15:0];
						o.out_alpha = 13'd4096;
					end else begin
						o.out_red = 16'((s[0] + 8) >> 4);
						o.out_green = 16'((s[1] + 8) >> 4);
						o.out_blue = 16'((s[2] + 8) >> 4);
						o.out_alpha = '0;
					end
					o.frame_end = (row_pos / 2 == frame_h / 2 - 1) &&
						(col_pos / 2 == frame_w / 2 - 1);
					expected_pixels.insert(expected_pixels.size(), o);
				end
			end
		end
		col_pos++;
		if (col_pos >= frame_w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= frame_h) row_pos = 0;
		end
	endfunction

	// Output side: random backpressure and in-order compare.
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				pixels_out++;
				if (out_data.frame_end) frames_done++;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxErrReport)
						$display("unexpected output transaction %p", out_data);
				end else begin
					pix_out_t e;
					e = expected_pixels.pop_front();
					if (out_data !== e) begin
						mismatches++;
						if (mismatches <= MaxErrReport)
							$display("pixel %0d mismatch: exp %p got %p", pixels_out, e, out_data);
					end
				end
				out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
				out_ready <= (out_gap == 0);
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= (out_gap == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("== FAIL ==");
			$display("watchdog expired, %0d results outstanding", expected_pixels.size());
			timed_out = 1'b1;
			$finish;
		end
	end

	// Send one pixel after a random gap; hold valid and payload until accepted.
	// Valid is left high after acceptance; a drain or the gap before the next send drops it.
	task automatic send_pixel(pix_in_t p, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= p;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decimate_pixel(p);
		pixels_in++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_size(logic idx, logic [12:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_size(idx, v);
	endtask

	function automatic pix_in_t random_pixel();
		pix_in_t p;
		p.in_red = 16'($urandom);
		p.in_green = 16'($urandom);
		p.in_blue = 16'($urandom);
		case ($urandom_range(0, 5))
			0: p.in_alpha = '0;
			1: p.in_alpha = 13'd4096;
			2: p.in_alpha = 13'h1FFF;         // coverage above one
			default: p.in_alpha = 13'($urandom_range(0, 4096));
		endcase
		return p;
	endfunction

	// Directed table: a 4x4 frame, extremes of every channel.
	// Rows with a typed-in result carry a known output for the odd/odd pixel.
	typedef struct {
		pix_in_t px;
		bit has_known;
		pix_out_t known;
	} dir_row_t;
	dir_row_t dir_rows [16];

	task automatic run_directed();
		pix_out_t pred;
		for (int i = 0; i < 16; i++) begin
			dir_rows[i].has_known = 1'b0;
			dir_rows[i].px = '0;
			case (i % 4)
				0: dir_rows[i].px = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd4096};
				1: dir_rows[i].px = '{16'h0000, 16'h0000, 16'h0000, 13'd0};
				2: dir_rows[i].px = '{16'h1000, 16'h8000, 16'hFFFF, 13'h1FFF};
				default: dir_rows[i].px = '{16'hFFFF, 16'h0001, 16'h0000, 13'd1};
			endcase
		end
		// all-zero top-left block: zero alpha gives plain rounded sums of zero
		dir_rows[0].px = '0;
		dir_rows[1].px = '0;
		dir_rows[4].px = '0;
		dir_rows[5].px = '0;
		dir_rows[5].has_known = 1'b1;
		dir_rows[5].known = '{16'h0, 16'h0, 16'h0, 13'd0, 1'b0};
		for (int i = 0; i < 16; i++) begin
			send_pixel(dir_rows[i].px, 1'b0);
			if (dir_rows[i].has_known) begin
				pred = expected_pixels[$];
				if (pred !== dir_rows[i].known) begin
					mismatches++;
					$display("table row %0d: typed %p, predicted %p", i, dir_rows[i].known, pred);
				end
			end
		end
	endtask

	// One frame of random pixels, or a broken partial one if chop is set.
	task automatic random_frame(bit chop);
		int n;
		bit burst;
		n = frame_w * frame_h;
		if (chop) n = $urandom_range(1, n);
		burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) send_pixel(random_pixel(), burst);
	endtask

	int phase;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		frame_w = clamp_size(13'd1024, MaxW);
		frame_h = clamp_size(13'd512, MaxH);
		restart_frame();

		// small sizes for the table, then sizes below the minimum clamp to two
		write_size(CfgWidthIdx, 13'd4);
		write_size(CfgHeightIdx, 13'd4);
		run_directed();
		wait_drained();
		write_size(CfgWidthIdx, 13'd0);
		write_size(CfgHeightIdx, 13'd1);
		random_frame(1'b0);
		random_frame(1'b0);
		wait_drained();

		// width beyond the maximum: a partial first row only
		write_size(CfgWidthIdx, 13'h1FFF);
		write_size(CfgHeightIdx, 13'd2);
		for (int i = 0; i < 200; i++) send_pixel(random_pixel(), 1'b0);
		wait_drained();

		// odd sizes drop the last row and column
		write_size(CfgWidthIdx, 13'd7);
		write_size(CfgHeightIdx, 13'd5);
		random_frame(1'b0);
		wait_drained();

		phase = 0;
		while (pixels_in < RandItems) begin
			write_size(CfgWidthIdx, 13'($urandom_range(2, 12)));
			write_size(CfgHeightIdx, 13'($urandom_range(2, 10)));
			random_frame(phase % 7 == 6);
			if (phase % 7 != 6) random_frame(1'b0);
			// hold off until the block has emptied
			wait_drained();
			phase++;
		end

		wait_drained();
		if (!timed_out) begin
			$display("Sent %0d pixels over %0d size settings, checked %0d outputs",
				pixels_in, phase + 4, pixels_out);
			$display("(%0d complete output frames seen).", frames_done);
			if (mismatches == 0 && expected_pixels.size() == 0) begin
				$display("== PASS ==");
			end else begin
				$display("== FAIL ==");
			end
			$finish;
		end
	end
endmodule
